[design/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg: shared definitions for the shortest path matrix unit
// Sizes, distance encodings, command and state codes, and helpers used by
// the top level and the weight RAM instance.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int MAX_VERTICES  = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int RESULT_CAP    = 16;
   localparam int USE_LIMIT     = (MAX_VERTICES < RESULT_CAP) ? MAX_VERTICES : RESULT_CAP;

   localparam int VIDX_BITS     = $clog2(MAX_VERTICES);
   localparam int RAM_DEPTH     = MAX_VERTICES * MAX_VERTICES;
   localparam int RAM_ADDR_BITS = $clog2(RAM_DEPTH);

   localparam int CNT_BITS      = 5;
   localparam int NAME_BITS     = 8;
   localparam int DIST_BITS     = 21;
   localparam int OUT_DIST_BITS = 20;
   localparam int SUM_BITS      = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

   localparam logic [DIST_BITS-1:0]     DIST_INF     = '1;
   localparam logic [DIST_BITS-1:0]     DIST_SAT     = DIST_INF - 1'b1;
   localparam logic [OUT_DIST_BITS-1:0] OUT_DIST_MAX = '1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic [CNT_BITS-1:0] VERTEX_COUNT_RESET = CNT_BITS'(16);

   typedef enum logic [1:0] {
      CMD_NAME   = 2'd0,
      CMD_WEIGHT = 2'd1,
      CMD_RUN    = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_SELECT = 5'b00100,
      ST_RELAX  = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   function automatic logic [VIDX_BITS-1:0] last_slot(input logic [CNT_BITS-1:0] cnt);
      int n;
      n = int'(cnt);
      if (n == 0) n = 1;
      if (n > USE_LIMIT) n = USE_LIMIT;
      return VIDX_BITS'(n - 1);
   endfunction

endpackage

[design/spm_ram.sv]
// ----------------------------------------------------------------------------
// spm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/shortest_path_matrix_unit.sv]
// ----------------------------------------------------------------------------
// shortest_path_matrix_unit: single-source shortest paths over a weight matrix
// Name and weight writes, then Dijkstra runs from a named start vertex.
// ----------------------------------------------------------------------------
// A run beat holds the input for the whole search: a name lookup, then for
// each reachable vertex a minimum search and a relaxation through the
// single read port of the weight RAM, then one last minimum search that
// finds nothing, then one result beat per vertex in use, plus any output
// stall; a start name that is not found gives one start-missing beat
// instead. One compare unit does the minimum searches and one add/compare
// unit the relaxations. The input is taken again as soon as the last result
// beat is loaded into the output register.
module shortest_path_matrix_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_row_index,
   input  logic [3:0]  req_col_index,
   input  logic [15:0] req_edge_weight,
   input  logic [7:0]  req_vertex_name,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_vertex_slot,
   output logic [19:0] rsp_distance,
   output logic        rsp_reachable,
   output logic        rsp_start_missing,
   output logic        rsp_last_result,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [spm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [spm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [spm_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int VB = spm_pkg::VIDX_BITS;
   localparam int DB = spm_pkg::DIST_BITS;
   localparam int AB = spm_pkg::RAM_ADDR_BITS;
   localparam int SB = spm_pkg::SUM_BITS;

   spm_pkg::state_type state_ff, state_in;

   logic [spm_pkg::CNT_BITS-1:0]   vcount_ff, vcount_in;
   logic [spm_pkg::NAME_BITS-1:0]  name_ff [spm_pkg::MAX_VERTICES];
   logic [spm_pkg::NAME_BITS-1:0]  name_in [spm_pkg::MAX_VERTICES];
   logic [DB-1:0]                  dist_ff [spm_pkg::MAX_VERTICES];
   logic [DB-1:0]                  dist_in [spm_pkg::MAX_VERTICES];
   logic [spm_pkg::MAX_VERTICES-1:0] visited_ff, visited_in;

   logic [spm_pkg::NAME_BITS-1:0]  start_name_ff, start_name_in;
   logic [VB-1:0]                  scan_ff, scan_in;
   logic [VB-1:0]                  cur_ff, cur_in;
   logic [DB-1:0]                  cur_dist_ff, cur_dist_in;
   logic [DB-1:0]                  best_ff, best_in;
   logic                           have_ff, have_in;
   logic                           missing_ff, missing_in;
   logic [VB-1:0]                  issue_ff, issue_in;
   logic                           issue_on_ff, issue_on_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [VB-1:0]                  rd_idx_ff, rd_idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [3:0]                     rsp_slot_ff, rsp_slot_in;
   logic [19:0]                    rsp_dist_ff, rsp_dist_in;
   logic                           rsp_reach_ff, rsp_reach_in;
   logic                           rsp_missing_ff, rsp_missing_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                              req_fire;
   logic                              row_ok;
   logic                              col_ok;
   logic                              csr_write;
   logic [VB-1:0]                     last_idx;
   logic                              ram_wr_en;
   logic [AB-1:0]                     ram_wr_addr;
   logic [AB-1:0]                     ram_rd_addr;
   logic [spm_pkg::WEIGHT_BITS-1:0]   ram_rd_data;

   logic [DB-1:0]                     sel_dist;
   logic                              sel_take;
   logic                              fin_have;
   logic [VB-1:0]                     fin_cur;
   logic [DB-1:0]                     fin_best;
   logic [SB-1:0]                     rlx_sum;
   logic [DB-1:0]                     rlx_sat;
   logic                              rlx_take;
   logic                              rep_reach;
   logic [19:0]                       rep_shown;

   assign req_ready  = (state_ff == spm_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign row_ok     = int'(req_row_index) < spm_pkg::MAX_VERTICES;
   assign col_ok     = int'(req_col_index) < spm_pkg::MAX_VERTICES;
   assign last_idx   = spm_pkg::last_slot(vcount_ff);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[spm_pkg::CSR_ADDR_BITS-1] == spm_pkg::REG_VERTEX_COUNT);
   assign csr_prdata = (csr_paddr[spm_pkg::CSR_ADDR_BITS-1] == spm_pkg::REG_VERTEX_COUNT) ?
                       spm_pkg::CSR_DATA_BITS'(vcount_ff) : '0;

   assign ram_wr_en   = req_fire && (req_cmd == spm_pkg::CMD_WEIGHT) && row_ok && col_ok;
   assign ram_wr_addr = AB'(VB'(req_row_index)) * AB'(spm_pkg::MAX_VERTICES) +
                        AB'(VB'(req_col_index));
   assign ram_rd_addr = AB'(cur_ff) * AB'(spm_pkg::MAX_VERTICES) + AB'(issue_ff);

   spm_ram #(
      .WIDTH (spm_pkg::WEIGHT_BITS),
      .DEPTH (spm_pkg::RAM_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (spm_pkg::WEIGHT_BITS'(req_edge_weight)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared compare unit for the minimum search
   assign sel_dist = dist_ff[scan_ff];
   assign sel_take = !visited_ff[scan_ff] && (sel_dist != spm_pkg::DIST_INF) &&
                     (sel_dist < best_ff);
   assign fin_have = have_ff || sel_take;
   assign fin_cur  = sel_take ? scan_ff : cur_ff;
   assign fin_best = sel_take ? sel_dist : best_ff;

   // shared add/compare unit for relaxation
   assign rlx_sum  = SB'(cur_dist_ff) + SB'(ram_rd_data);
   assign rlx_sat  = (rlx_sum > SB'(spm_pkg::DIST_SAT)) ? spm_pkg::DIST_SAT : DB'(rlx_sum);
   assign rlx_take = rd_valid_ff && (ram_rd_data != '0) && !visited_ff[rd_idx_ff] &&
                     (rlx_sat < dist_ff[rd_idx_ff]);

   assign rep_reach = (sel_dist != spm_pkg::DIST_INF);
   assign rep_shown = !rep_reach ? 20'd0 :
                      (sel_dist > DB'(spm_pkg::OUT_DIST_MAX)) ? spm_pkg::OUT_DIST_MAX :
                      20'(sel_dist);

   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      name_in       = name_ff;
      dist_in       = dist_ff;
      visited_in    = visited_ff;
      start_name_in = start_name_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      cur_dist_in   = cur_dist_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      missing_in    = missing_ff;
      issue_in      = issue_ff;
      issue_on_in   = issue_on_ff;
      rd_valid_in   = (state_ff == spm_pkg::ST_RELAX) && issue_on_ff;
      rd_idx_in     = issue_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_missing_in = rsp_missing_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write) begin
         vcount_in = csr_pwdata[spm_pkg::CNT_BITS-1:0];
      end

      unique case (state_ff)
         spm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  spm_pkg::CMD_NAME: begin
                     if (row_ok) begin
                        name_in[VB'(req_row_index)] = req_vertex_name;
                     end
                  end
                  spm_pkg::CMD_WEIGHT: begin
                  end
                  spm_pkg::CMD_RUN: begin
                     for (int i = 0; i < spm_pkg::MAX_VERTICES; i++) begin
                        dist_in[i] = spm_pkg::DIST_INF;
                     end
                     visited_in    = '0;
                     start_name_in = req_vertex_name;
                     missing_in    = 1'b0;
                     scan_in       = '0;
                     state_in      = spm_pkg::ST_LOOKUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         spm_pkg::ST_LOOKUP: begin
            if (name_ff[scan_ff] == start_name_ff) begin
               dist_in[scan_ff] = '0;
               scan_in  = '0;
               best_in  = spm_pkg::DIST_INF;
               have_in  = 1'b0;
               state_in = spm_pkg::ST_SELECT;
            end else if (scan_ff == last_idx) begin
               missing_in = 1'b1;
               scan_in    = '0;
               state_in   = spm_pkg::ST_REPORT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         spm_pkg::ST_SELECT: begin
            if (sel_take) begin
               best_in = sel_dist;
               cur_in  = scan_ff;
               have_in = 1'b1;
            end
            if (scan_ff == last_idx) begin
               if (fin_have) begin
                  visited_in[fin_cur] = 1'b1;
                  cur_in      = fin_cur;
                  cur_dist_in = fin_best;
                  issue_in    = '0;
                  issue_on_in = 1'b1;
                  state_in    = spm_pkg::ST_RELAX;
               end else begin
                  scan_in  = '0;
                  state_in = spm_pkg::ST_REPORT;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         spm_pkg::ST_RELAX: begin
            if (issue_on_ff) begin
               if (issue_ff == last_idx) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_in = issue_ff + 1'b1;
               end
            end
            if (rlx_take) begin
               dist_in[rd_idx_ff] = rlx_sat;
            end
            if (rd_valid_ff && (rd_idx_ff == last_idx)) begin
               scan_in  = '0;
               best_in  = spm_pkg::DIST_INF;
               have_in  = 1'b0;
               state_in = spm_pkg::ST_SELECT;
            end
         end
         spm_pkg::ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (missing_ff) begin
                  rsp_slot_in    = '0;
                  rsp_dist_in    = '0;
                  rsp_reach_in   = 1'b0;
                  rsp_missing_in = 1'b1;
                  rsp_last_in    = 1'b1;
                  state_in       = spm_pkg::ST_IDLE;
               end else begin
                  rsp_slot_in    = 4'(scan_ff);
                  rsp_dist_in    = rep_shown;
                  rsp_reach_in   = rep_reach;
                  rsp_missing_in = 1'b0;
                  rsp_last_in    = (scan_ff == last_idx);
                  if (scan_ff == last_idx) begin
                     state_in = spm_pkg::ST_IDLE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = spm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spm_pkg::ST_IDLE;
         vcount_ff    <= spm_pkg::VERTEX_COUNT_RESET;
         visited_ff   <= '0;
         for (int i = 0; i < spm_pkg::MAX_VERTICES; i++) begin
            dist_ff[i] <= spm_pkg::DIST_INF;
         end
         issue_on_ff  <= 1'b0;
         rd_valid_ff  <= 1'b0;
         missing_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         visited_ff   <= visited_in;
         dist_ff      <= dist_in;
         issue_on_ff  <= issue_on_in;
         rd_valid_ff  <= rd_valid_in;
         missing_ff   <= missing_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff        <= name_in;
      start_name_ff  <= start_name_in;
      scan_ff        <= scan_in;
      cur_ff         <= cur_in;
      cur_dist_ff    <= cur_dist_in;
      best_ff        <= best_in;
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_reach_ff   <= rsp_reach_in;
      rsp_missing_ff <= rsp_missing_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_slot   = rsp_slot_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_reachable     = rsp_reach_ff;
   assign rsp_start_missing = rsp_missing_ff;
   assign rsp_last_result   = rsp_last_ff;

   a_missing_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_missing_ff |-> rsp_last_ff && !rsp_reach_ff)
      else $error("start-missing beat not marked last");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_reach_ff |-> rsp_dist_ff == '0)
      else $error("unreachable beat carries a distance");

   a_relax_visited: assert property (@(posedge clock) disable iff (reset)
      state_ff == spm_pkg::ST_RELAX |-> visited_ff[cur_ff])
      else $error("relaxing from an unvisited vertex");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == spm_pkg::ST_IDLE |-> !rd_valid_ff && !issue_on_ff)
      else $error("weight read pending while idle");

   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      state_ff == spm_pkg::ST_IDLE && req_valid && req_cmd == spm_pkg::CMD_RUN
      |=> state_ff == spm_pkg::ST_LOOKUP)
      else $error("run beat did not start a lookup");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for shortest_path_matrix_unit
// Loads every vertex name and edge weight, then sends directed and random
// name, weight and run beats under several vertex counts and idle patterns.
// Each run is solved here by Dijkstra on a private copy of the matrix, and
// every result beat is checked against the oldest expected report.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_PERIOD  = 4;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 1500;
   localparam int RANDOM_BEATS  = 18;
   localparam int MAX_PRINTED   = 60;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [spm_pkg::CSR_ADDR_BITS-1:0] VERTEX_COUNT_ADDR =
      spm_pkg::CSR_ADDR_BITS'(4 * spm_pkg::REG_VERTEX_COUNT);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] weight;
      logic [7:0]  name;
   } request_beat_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [19:0] distance;
      logic        reachable;
      logic        start_missing;
      logic        last_result;
   } slot_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = 2'd0;
   logic [3:0]  req_row_index = 4'd0;
   logic [3:0]  req_col_index = 4'd0;
   logic [15:0] req_edge_weight = 16'd0;
   logic [7:0]  req_vertex_name = 8'd0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_vertex_slot;
   logic [19:0] rsp_distance;
   logic        rsp_reachable;
   logic        rsp_start_missing;
   logic        rsp_last_result;

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [spm_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [spm_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [spm_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   logic [15:0] edge_weights [spm_pkg::MAX_VERTICES][spm_pkg::MAX_VERTICES];
   logic [7:0]  vertex_names [spm_pkg::MAX_VERTICES];
   logic [4:0]  vertex_count = spm_pkg::VERTEX_COUNT_RESET;

   request_beat_type pending_beats [$];
   slot_report_type  expected_reports [$];
   request_beat_type next_beat;
   slot_report_type  next_report;

   logic req_beat_done = 1'b0;
   logic rsp_hold = 1'b0;
   int   sender_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   shortest_path_matrix_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_edge_weight   (req_edge_weight),
      .req_vertex_name   (req_vertex_name),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_slot   (rsp_vertex_slot),
      .rsp_distance      (rsp_distance),
      .rsp_reachable     (rsp_reachable),
      .rsp_start_missing (rsp_start_missing),
      .rsp_last_result   (rsp_last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void queue_beat(input request_beat_type b);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic void queue_report(input slot_report_type r);
      expected_reports.insert(expected_reports.size(), r);
   endfunction

   function automatic int in_use_count();
      int n;
      n = int'(vertex_count);
      if (n == 0) n = 1;
      if (n > spm_pkg::USE_LIMIT) n = spm_pkg::USE_LIMIT;
      return n;
   endfunction

   // Dijkstra over the private matrix; queue one report per vertex in use, or a single start-missing report
   function automatic void solve_paths(input logic [7:0] start_name);
      logic [spm_pkg::DIST_BITS-1:0] path_len [spm_pkg::MAX_VERTICES];
      bit                            settled [spm_pkg::MAX_VERTICES];
      logic [spm_pkg::DIST_BITS-1:0] best;
      logic [spm_pkg::DIST_BITS:0]   sum;
      slot_report_type               r;
      int                            n;
      int                            start;
      int                            cur;
      n = in_use_count();
      start = -1;
      for (int i = 0; i < n; i++) begin
         if (start < 0 && vertex_names[i] == start_name) start = i;
      end
      if (start < 0) begin
         r = '{slot: 4'd0, distance: 20'd0, reachable: 1'b0, start_missing: 1'b1,
               last_result: 1'b1};
         queue_report(r);
         return;
      end
      for (int i = 0; i < spm_pkg::MAX_VERTICES; i++) begin
         path_len[i] = spm_pkg::DIST_INF;
         settled[i] = 1'b0;
      end
      path_len[start] = '0;
      do begin
         cur = -1;
         best = spm_pkg::DIST_INF;
         for (int i = 0; i < n; i++) begin
            if (!settled[i] && path_len[i] < best) begin
               best = path_len[i];
               cur = i;
            end
         end
         if (cur >= 0) begin
            settled[cur] = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (edge_weights[cur][i] != 0 && !settled[i]) begin
                  sum = path_len[cur] + edge_weights[cur][i];
                  if (sum > spm_pkg::DIST_SAT) sum = spm_pkg::DIST_SAT;
                  if (sum < path_len[i]) path_len[i] = sum[spm_pkg::DIST_BITS-1:0];
               end
            end
         end
      end while (cur >= 0);
      for (int i = 0; i < n; i++) begin
         r.slot = 4'(i);
         r.reachable = (path_len[i] != spm_pkg::DIST_INF);
         if (!r.reachable) r.distance = '0;
         else if (path_len[i] > spm_pkg::OUT_DIST_MAX) r.distance = spm_pkg::OUT_DIST_MAX;
         else r.distance = path_len[i][spm_pkg::OUT_DIST_BITS-1:0];
         r.start_missing = 1'b0;
         r.last_result = (i == n - 1);
         queue_report(r);
      end
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got 0x%0h want 0x%0h (slot %0d)", field, got, want,
                                 next_report.slot));
   endtask

   function automatic request_beat_type make_beat(input logic [1:0] cmd, input int row,
                                                  input int col, input logic [15:0] weight,
                                                  input logic [7:0] name);
      request_beat_type b;
      b.cmd = cmd;
      b.row = 4'(row);
      b.col = 4'(col);
      b.weight = weight;
      b.name = name;
      return b;
   endfunction

   function automatic logic [15:0] random_weight();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return 16'd0;
      if (pick < 45) return 16'hFFFF;
      if (pick < 65) return 16'($urandom_range(1, 15));
      return 16'($urandom);
   endfunction

   function automatic request_beat_type random_beat();
      request_beat_type b;
      int pick;
      b = make_beat(2'($urandom), $urandom_range(15), $urandom_range(15),
                    16'($urandom), 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 8) begin
         b.cmd = CMD_UNUSED;
      end else if (pick < 28) begin
         b.cmd = spm_pkg::CMD_RUN;
         if ($urandom_range(99) < 80) b.name = 8'h41 + 8'($urandom_range(15));
      end else if (pick < 50) begin
         b.cmd = spm_pkg::CMD_NAME;
         if ($urandom_range(99) < 85) b.name = 8'h41 + 8'($urandom_range(11));
      end else begin
         b.cmd = spm_pkg::CMD_WEIGHT;
         b.weight = random_weight();
      end
      return b;
   endfunction

   task automatic push_random(input int target);
      request_beat_type b;
      int counted;
      counted = 0;
      while (counted < target) begin
         b = random_beat();
         queue_beat(b);
         if (b.cmd != CMD_UNUSED) counted++;
      end
   endtask

   task automatic push_run(input logic [7:0] name);
      queue_beat(make_beat(spm_pkg::CMD_RUN, $urandom_range(15), $urandom_range(15),
                           16'($urandom), name));
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [4:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= VERTEX_COUNT_ADDR;
      csr_pwdata <= spm_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      vertex_count = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // track accepted request beats and predict
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         case (req_cmd)
            spm_pkg::CMD_NAME:   vertex_names[req_row_index] = req_vertex_name;
            spm_pkg::CMD_WEIGHT: edge_weights[req_row_index][req_col_index] = req_edge_weight;
            spm_pkg::CMD_RUN:    solve_paths(req_vertex_name);
            default:             ;
         endcase
      end
      req_beat_done <= !reset && req_valid && req_ready;
   end

   // request driver: advance on an accepted beat, else hold
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_beat.cmd;
            req_row_index <= next_beat.row;
            req_col_index <= next_beat.col;
            req_edge_weight <= next_beat.weight;
            req_vertex_name <= next_beat.name;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            flag_mismatch("result beat with no run pending");
         end else begin
            next_report = expected_reports.pop_front();
            check_field("vertex_slot", rsp_vertex_slot, next_report.slot);
            check_field("distance", rsp_distance, next_report.distance);
            check_field("reachable", rsp_reachable, next_report.reachable);
            check_field("start_missing", rsp_start_missing, next_report.start_missing);
            check_field("last_result", rsp_last_result, next_report.last_result);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                  expected_reports.size());
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      logic [4:0] count_plan [8];
      count_plan = '{5'd1, 5'd0, 5'd5, 5'd31, 5'd17, 5'($urandom_range(2, 15)), 5'd2, 5'd16};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_vertex_count(5'd16);

      // load the whole matrix and every name before any run
      for (int r = 0; r < spm_pkg::MAX_VERTICES; r++) begin
         queue_beat(make_beat(spm_pkg::CMD_NAME, r, $urandom_range(15), 16'($urandom),
                              8'h41 + 8'(r)));
         for (int c = 0; c < spm_pkg::MAX_VERTICES; c++)
            queue_beat(make_beat(spm_pkg::CMD_WEIGHT, r, c, random_weight(),
                                 8'($urandom)));
      end

      push_run(8'h41);
      push_run(8'h50);
      push_run(8'h00);
      queue_beat(make_beat(CMD_UNUSED, 15, 15, 16'hFFFF, 8'hFF));
      queue_beat(make_beat(spm_pkg::CMD_WEIGHT, 15, 15, 16'hFFFF, 8'h00));
      queue_beat(make_beat(spm_pkg::CMD_WEIGHT, 0, 15, 16'hFFFF, 8'h00));
      queue_beat(make_beat(spm_pkg::CMD_WEIGHT, 15, 0, 16'h0000, 8'h00));
      queue_beat(make_beat(spm_pkg::CMD_WEIGHT, 0, 1, 16'h0001, 8'hFF));
      queue_beat(make_beat(spm_pkg::CMD_NAME, 15, 0, 16'h0000, 8'hFF));
      push_run(8'hFF);
      queue_beat(make_beat(spm_pkg::CMD_NAME, 4, 0, 16'h0000, 8'h41));
      push_run(8'h41);
      wait_idle();

      // hold off results while runs keep coming, so the input backs up
      fork
         begin
            rsp_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      push_run(8'h41);
      push_run(8'h42);
      queue_beat(make_beat(spm_pkg::CMD_WEIGHT, 2, 3, 16'h0007, 8'h00));
      push_run(8'h43);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_vertex_count(count_plan[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin sender_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         push_run(vertex_names[0]);
         push_run(vertex_names[in_use_count() - 1]);
         push_random(RANDOM_BEATS);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
